FILE: hdl/sliding_window_median_core_macros.svh
// Assertion helpers used by the core RTL file.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SWM_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the condition.
`define SWM_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: hdl/swm_pkg.sv
package swm_pkg;
    localparam int MaxWindow  = 25;
    localparam int SampleBits = 32;
    localparam int IdxBits    = 5;
    localparam int NetLen     = 13 + 19 + 99 + 3 + 7;
    localparam int StepBits   = 8;

    typedef logic [IdxBits-1:0]    idx_t;
    typedef logic [StepBits-1:0]   step_t;
    typedef logic signed [SampleBits-1:0] sample_t;

    // Flattened pair lists: net3 at 0, net5 at 3, net7 at 10, net9 at 23, net25 at 42.
    localparam int Pairs [0:2*141-1] = '{
        0,1, 1,2, 0,1,
        0,1, 3,4, 0,3, 1,4, 1,2, 2,3, 1,2,
        0,5, 0,3, 1,6, 2,4, 0,1, 3,5, 2,6, 2,3, 3,6, 4,5, 1,4, 1,3, 3,4,
        1,2, 4,5, 7,8, 0,1, 3,4, 6,7, 1,2, 4,5, 7,8, 0,3, 5,8, 4,7, 3,6,
        1,4, 2,5, 4,7, 4,2, 6,4, 4,2,
        0,1, 3,4, 2,4, 2,3, 6,7, 5,7, 5,6, 9,10, 8,10, 8,9,
        12,13, 11,13, 11,12, 15,16, 14,16, 14,15, 18,19, 17,19, 17,18, 21,22,
        20,22, 20,21, 23,24, 2,5, 3,6, 0,6, 0,3, 4,7, 1,7, 1,4,
        11,14, 8,14, 8,11, 12,15, 9,15, 9,12, 13,16, 10,16, 10,13, 20,23,
        17,23, 17,20, 21,24, 18,24, 18,21, 19,22, 8,17, 9,18, 0,18, 0,9,
        10,19, 1,19, 1,10, 11,20, 2,20, 2,11, 12,21, 3,21, 3,12, 13,22,
        4,22, 4,13, 14,23, 5,23, 5,14, 15,24, 6,24, 6,15, 7,16, 7,19,
        13,21, 15,23, 7,13, 7,15, 1,9, 3,11, 5,17, 11,17, 9,17, 4,10,
        6,12, 7,14, 4,6, 4,7, 12,14, 10,14, 6,7, 10,12, 6,10, 6,17,
        12,17, 7,17, 7,10, 12,18, 7,12, 10,18, 12,20, 10,20, 10,12 };

    function automatic idx_t pair_a(input step_t s);
        return idx_t'(Pairs[2*int'(s)]);
    endfunction

    function automatic idx_t pair_b(input step_t s);
        return idx_t'(Pairs[2*int'(s)+1]);
    endfunction

    // Network selection for a window size.
    typedef struct packed {
        logic  ok;
        step_t first;
        step_t last;
        idx_t  mid;
    } net_sel_t;

    function automatic net_sel_t net_for(input idx_t size);
        net_sel_t n;
        n = '{ok: 1'b0, first: '0, last: '0, mid: '0};
        unique case (size)
            idx_t'(3):  n = '{ok: 1'b1, first: step_t'(0),  last: step_t'(2),   mid: idx_t'(1)};
            idx_t'(5):  n = '{ok: 1'b1, first: step_t'(3),  last: step_t'(9),   mid: idx_t'(2)};
            idx_t'(7):  n = '{ok: 1'b1, first: step_t'(10), last: step_t'(22),  mid: idx_t'(3)};
            idx_t'(9):  n = '{ok: 1'b1, first: step_t'(23), last: step_t'(41),  mid: idx_t'(4)};
            idx_t'(25): n = '{ok: 1'b1, first: step_t'(42), last: step_t'(140), mid: idx_t'(12)};
            default: ;
        endcase
        return n;
    endfunction
endpackage

FILE: hdl/swm_cmp_exch.sv
// The single shared compare-exchange unit: orders two signed samples.
module swm_cmp_exch (
    input  swm_pkg::sample_t a_in,
    input  swm_pkg::sample_t b_in,
    output swm_pkg::sample_t lo_out,
    output swm_pkg::sample_t hi_out,
    output logic             swap_out
);
    assign swap_out = a_in > b_in;
    assign lo_out   = swap_out ? b_in : a_in;
    assign hi_out   = swap_out ? a_in : b_in;
endmodule

FILE: hdl/sliding_window_median_core.sv
// Channel | ports                         | direction
// input   | s_valid s_ready s_sample      | in
// result  | m_valid m_ready m_median      | out
// config  | cfg_we cfg_wdata              | in
//
// With a supported size, each sample runs through the compare-exchanges
// of the chosen network (3 to 99), one per cycle on the one shared
// comparator, and no new sample is taken until the block is back in ST_IDLE.
// An unsupported size skips the network and gives a zero result.
// The result is registered in ST_DONE, after the network steps in ST_SORT.
// Reset clears the window to zero, the pointer to zero and the size to 3.
// A result waits in the output register; the next sample is taken as
// soon as that register is free or being emptied.
`include "sliding_window_median_core_macros.svh"
module sliding_window_median_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  swm_pkg::sample_t     s_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output swm_pkg::sample_t     m_median
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SORT = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    swm_pkg::idx_t      size_reg, ptr_reg;
    swm_pkg::sample_t   store_reg [swm_pkg::MaxWindow];
    // Working copy that the network permutes.
    swm_pkg::sample_t   work_reg  [swm_pkg::MaxWindow];
    swm_pkg::step_t     step_reg;
    swm_pkg::net_sel_t  net_reg;
    logic               m_valid_reg;
    swm_pkg::sample_t   median_reg;

    swm_pkg::idx_t     ia, ib, ptr_use, ptr_inc;
    swm_pkg::sample_t  lo, hi;
    logic              swp;
    swm_pkg::net_sel_t net_sel;

    assign ia = swm_pkg::pair_a(step_reg);
    assign ib = swm_pkg::pair_b(step_reg);

    // Network chosen by the current window size.
    assign net_sel = swm_pkg::net_for(size_reg);

    swm_cmp_exch u_cx (
        .a_in(work_reg[ia]), .b_in(work_reg[ib]),
        .lo_out(lo), .hi_out(hi), .swap_out(swp)
    );

    // A sample may enter in idle when the output register is free or draining.
    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_median = median_reg;

    // Pointer wrap: a stale pointer beyond the store restarts at zero.
    assign ptr_use = (ptr_reg >= swm_pkg::idx_t'(swm_pkg::MaxWindow)) ? '0 : ptr_reg;
    assign ptr_inc = ptr_use + 1'b1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid && s_ready) state_next = ST_SORT;
            ST_SORT: if (!net_reg.ok || step_reg == net_reg.last) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_reg    <= swm_pkg::idx_t'(3);
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
            net_reg     <= '0;
            for (int i = 0; i < swm_pkg::MaxWindow; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            // The result register fills at the end of a sort and empties on a transfer.
            if (state_reg == ST_DONE) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        store_reg[ptr_use] <= s_sample;
                        // The pointer wraps at the window size, capped by the store depth.
                        ptr_reg  <= (ptr_inc >= size_reg ||
                                     ptr_inc >= swm_pkg::idx_t'(swm_pkg::MaxWindow)) ?
                                    '0 : ptr_inc;
                        net_reg  <= net_sel;
                        step_reg <= net_sel.first;
                    end
                end
                ST_SORT: step_reg <= step_reg + 1'b1;
                ST_DONE: ;
                default: ;
            endcase
        end
    end

    // Payload: copy the store after the write, then permute the copy.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            for (int i = 0; i < swm_pkg::MaxWindow; i++) begin
                work_reg[i] <= store_reg[i];
            end
            if (s_valid && s_ready) begin
                work_reg[ptr_use] <= s_sample;
            end
        end else if (state_reg == ST_SORT && net_reg.ok) begin
            work_reg[ia] <= lo;
            work_reg[ib] <= hi;
        end
        if (state_reg == ST_DONE) begin
            median_reg <= net_reg.ok ? work_reg[net_reg.mid] : '0;
        end
    end

    `SWM_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE)
    `SWM_ASSERT_NEXT(a_done_valid, aclk, aresetn, state_reg == ST_DONE, m_valid)
    `SWM_ASSERT_IMP(a_ptr_range, aclk, aresetn, 1'b1,
        ptr_reg < swm_pkg::idx_t'(swm_pkg::MaxWindow))
    `SWM_ASSERT_IMP(a_sort_net, aclk, aresetn, state_reg == ST_SORT && net_reg.ok,
        step_reg >= net_reg.first && step_reg <= net_reg.last)
endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
    // Window sizes that select a sorting network; every other size yields zero.
    localparam logic [4:0] SizeThree      = 5'd3;
    localparam logic [4:0] SizeFive       = 5'd5;
    localparam logic [4:0] SizeSeven      = 5'd7;
    localparam logic [4:0] SizeNine       = 5'd9;
    localparam logic [4:0] SizeTwentyFive = 5'd25;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [4:0]        cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    swm_pkg::sample_t  s_sample;
    logic              m_valid;
    logic              m_ready;
    swm_pkg::sample_t  m_median;

    // Shadow copy of the filter state, advanced on every accepted transfer.
    swm_pkg::sample_t  win_mirror [swm_pkg::MaxWindow];
    int unsigned       wr_ptr_mirror;
    logic [4:0]        size_mirror;

    swm_pkg::sample_t  median_queue [$];
    int                error_count;
    int                results_seen;

    sliding_window_median_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_median  (m_median)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop. The slowest legal run is about 2500 items with the longest
    // gaps and stalls, well under this limit.
    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Picks a gap length: mostly none or short, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 150);
    endfunction

    // Median of the window after the sample is written, computed with a plain
    // insertion sort of the first size entries. This is equivalent to the
    // compare-exchange networks, which always produce a correct median.
    function automatic swm_pkg::sample_t window_median(input logic [4:0] size);
        swm_pkg::sample_t sorted [swm_pkg::MaxWindow];
        swm_pkg::sample_t t;
        int               n;
        int               i;
        int               j;
        n = int'(size);
        if (!(size == SizeThree || size == SizeFive || size == SizeSeven ||
              size == SizeNine || size == SizeTwentyFive)) begin
            return '0;
        end
        for (i = 0; i < n; i++) begin
            sorted[i] = win_mirror[i];
        end
        for (i = 1; i < n; i++) begin
            t = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > t) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = t;
        end
        return sorted[n / 2];
    endfunction

    // Writes the sample into the shadow window, advances the pointer and
    // queues the expected median.
    task automatic push_sample(input swm_pkg::sample_t smp);
        int unsigned lim;
        int unsigned nxt;
        lim = (size_mirror < swm_pkg::MaxWindow) ? size_mirror : swm_pkg::MaxWindow;
        if (wr_ptr_mirror >= swm_pkg::MaxWindow) begin
            wr_ptr_mirror = 0;
        end
        win_mirror[wr_ptr_mirror] = smp;
        nxt = wr_ptr_mirror + 1;
        if (nxt >= lim) begin
            nxt = 0;
        end
        wr_ptr_mirror = nxt;
        median_queue.push_back(window_median(size_mirror));
    endtask

    // Sends one sample with an optional random gap ahead of it. Valid stays
    // high with a steady payload until the transfer completes, then drops
    // before the next sample is offered.
    task automatic send_sample(input swm_pkg::sample_t smp);
        int unsigned gap;
        gap = gap_len();
        repeat (gap) @(posedge aclk);
        s_valid  <= 1'b1;
        s_sample <= smp;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        push_sample(smp);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every expected median has come back, then lets the block
    // settle before any register write.
    task automatic drain_results();
        while (median_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (110) @(posedge aclk);
    endtask

    task automatic write_size(input logic [4:0] size);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        size_mirror = size;
    endtask

    // Random sample with a bias toward extremes and repeated values, so that
    // equal entries and the sign boundary show up often.
    function automatic swm_pkg::sample_t random_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                return swm_pkg::sample_t'(32'h8000_0000);
            end
            1: begin
                return swm_pkg::sample_t'(32'h7fff_ffff);
            end
            2: begin
                return swm_pkg::sample_t'($urandom_range(0, 3)) - 2;
            end
            default: begin
                return swm_pkg::sample_t'($urandom());
            end
        endcase
    endfunction

    // Result side: random stalls, and every transfer is checked against the
    // oldest expectation.
    initial begin
        swm_pkg::sample_t want;
        int unsigned      stall;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (median_queue.size() == 0) begin
                    $error("median result with no expectation: actual %0d", m_median);
                    error_count++;
                end else begin
                    want = median_queue.pop_front();
                    if (m_median !== want) begin
                        $error("median mismatch: expected %0d actual %0d", want, m_median);
                        error_count++;
                    end
                end
            end
        end
    end

    // Extremes, sign boundary, equal values and the unfilled window at the
    // reset size of three.
    task automatic test_directed_extremes();
        send_sample(swm_pkg::sample_t'(32'h7fff_ffff));
        send_sample(swm_pkg::sample_t'(32'h8000_0000));
        send_sample(swm_pkg::sample_t'(32'hffff_ffff));
        send_sample(swm_pkg::sample_t'(32'h0000_0001));
        send_sample(swm_pkg::sample_t'(32'h0001_0000));
        send_sample(swm_pkg::sample_t'(32'h0001_0000));
        send_sample(swm_pkg::sample_t'(32'h0001_0000));
        send_sample(swm_pkg::sample_t'(32'h5555_5555));
        send_sample(swm_pkg::sample_t'(32'haaaa_aaaa));
    endtask

    // Sizes 25, 5, 7 and 9, with the pointer left beyond a reduced size, then unsupported sizes.
    task automatic test_directed_sizes();
        int i;
        write_size(SizeTwentyFive);
        for (i = 0; i < 6; i++) begin
            send_sample(swm_pkg::sample_t'(32'h0000_0100 * (i + 1)) ^
                        swm_pkg::sample_t'(32'h8000_0000));
        end
        write_size(SizeFive);
        send_sample(swm_pkg::sample_t'(32'hc000_0000));
        write_size(SizeSeven);
        send_sample(swm_pkg::sample_t'(32'h3fff_ffff));
        write_size(SizeNine);
        send_sample(swm_pkg::sample_t'(-32'sd5));
        // Unsupported sizes still store the sample but report zero.
        write_size(5'd0);
        send_sample(swm_pkg::sample_t'(32'h1234_5678));
        write_size(5'd1);
        send_sample(swm_pkg::sample_t'(32'h1234_5678));
        write_size(5'd31);
        send_sample(swm_pkg::sample_t'(32'h1234_5678));
        write_size(5'd4);
        send_sample(swm_pkg::sample_t'(32'h8765_4321));
    endtask

    // Random phases over many sizes, the supported ones most of the time.
    task automatic test_random_stream();
        int          phase;
        int          i;
        int          n;
        logic [4:0]  size;
        for (phase = 0; phase < 35; phase++) begin
            case ($urandom_range(0, 7))
                0: size = SizeThree;
                1: size = SizeFive;
                2: size = SizeSeven;
                3: size = SizeNine;
                4, 5: size = SizeTwentyFive;
                default: size = 5'($urandom());
            endcase
            write_size(size);
            n = $urandom_range(30, 70);
            for (i = 0; i < n; i++) begin
                send_sample(random_sample());
            end
        end
    endtask

    initial begin
        error_count   = 0;
        results_seen  = 0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_sample      = '0;
        for (int k = 0; k < swm_pkg::MaxWindow; k++) begin
            win_mirror[k] = '0;
        end
        wr_ptr_mirror = 0;
        size_mirror   = SizeThree;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_directed_sizes();
        test_random_stream();
        write_size(SizeThree);
        send_sample(swm_pkg::sample_t'(32'h0000_0007));

        drain_results();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
